// ===== src/i2c_master_register_sequencer_top_defines.svh =====
// ----------------------------------------------------------------------------
// I2C register sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_SEQUENCER_TOP_DEFINES_SVH
`define I2C_MASTER_REGISTER_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register sequencer package
// Operation and bus command codes, item and result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_SEND   = 3'd2;
  localparam logic [2:0] CMD_RSTART = 3'd3;
  localparam logic [2:0] CMD_RECV   = 3'd4;
  localparam logic [2:0] CMD_ACK    = 3'd5;
  localparam logic [2:0] CMD_STOP   = 3'd6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  device_address;
    logic [15:0] register_address;
    logic [7:0]  transfer_length;
    logic        nack_seen;
    logic [7:0]  received_byte;
    logic [7:0]  next_write_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_command;
    logic [7:0] command_byte;
    logic       ack_level;
    logic       write_byte_taken;
    logic       read_valid;
    logic [7:0] read_data;
    logic       busy_res;
    logic       rejected;
  } result_t;

endpackage

// ===== src/i2cms_in_stage.sv =====
// ----------------------------------------------------------------------------
// I2C register sequencer input stage
// Registers one incoming transfer and holds it while the core is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cms_in_stage
  import i2cms_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  core_ready,
  output logic  s1_valid,
  output item_t s1_item
);

  assign in_stall = s1_valid && !core_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item <= in_item;
    end
  end

endmodule

// ===== src/i2cms_core.sv =====
// ----------------------------------------------------------------------------
// I2C register sequencer core
// Transfer phase FSM and result register; one item per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cms_core
  import i2cms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s1_valid,
  input  item_t   s1_item,
  output logic    core_ready,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_ADDR_W, PH_REG_HI, PH_REG_LO, PH_TX,
    PH_RESTART, PH_ADDR_R, PH_RX, PH_ACK, PH_STOP
  } phase_t;

  phase_t      phase, phase_next;
  logic [6:0]  target_address, target_address_next;
  logic [15:0] register_pointer, register_pointer_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic        read_mode, read_mode_next;
  logic        busy_flag, busy_flag_next;
  result_t     res_next;
  logic        step;

  assign core_ready = !out_valid || !out_stall;
  assign step       = s1_valid && core_ready;

  always_comb begin
    phase_next            = phase;
    target_address_next   = target_address;
    register_pointer_next = register_pointer;
    bytes_left_next       = bytes_left;
    read_mode_next        = read_mode;
    busy_flag_next        = busy_flag;
    res_next              = '0;
    res_next.bus_command  = CMD_NONE;

    if (s1_item.operation == OP_WRITE || s1_item.operation == OP_READ) begin
      if (busy_flag) begin
        res_next.rejected = 1'b1;
      end else begin
        target_address_next   = s1_item.device_address;
        register_pointer_next = s1_item.register_address;
        bytes_left_next       = s1_item.transfer_length;
        read_mode_next        = s1_item.operation[0];
        busy_flag_next        = 1'b1;
        phase_next            = PH_START;
        res_next.bus_command  = CMD_START;
      end
    end else if (s1_item.operation == OP_STEP && phase != PH_IDLE) begin
      if (phase != PH_START && phase != PH_STOP && s1_item.nack_seen) begin
        phase_next           = PH_STOP;
        res_next.bus_command = CMD_STOP;
      end else begin
        case (phase)
          PH_START: begin
            phase_next            = PH_ADDR_W;
            res_next.bus_command  = CMD_SEND;
            res_next.command_byte = {target_address, 1'b0};
          end
          PH_ADDR_W: begin
            phase_next            = PH_REG_HI;
            res_next.bus_command  = CMD_SEND;
            res_next.command_byte = register_pointer[15:8];
          end
          PH_REG_HI: begin
            phase_next            = PH_REG_LO;
            res_next.bus_command  = CMD_SEND;
            res_next.command_byte = register_pointer[7:0];
          end
          PH_REG_LO, PH_TX: begin
            if (read_mode && phase == PH_REG_LO) begin
              phase_next           = PH_RESTART;
              res_next.bus_command = CMD_RSTART;
            end else if (bytes_left != 8'd0) begin
              phase_next                = PH_TX;
              res_next.bus_command      = CMD_SEND;
              res_next.command_byte     = s1_item.next_write_byte;
              res_next.write_byte_taken = 1'b1;
              bytes_left_next           = bytes_left - 8'd1;
            end else begin
              phase_next           = PH_STOP;
              res_next.bus_command = CMD_STOP;
            end
          end
          PH_RESTART: begin
            phase_next            = PH_ADDR_R;
            res_next.bus_command  = CMD_SEND;
            res_next.command_byte = {target_address, 1'b1};
          end
          PH_ADDR_R: begin
            phase_next           = PH_RX;
            res_next.bus_command = CMD_RECV;
          end
          PH_RX: begin
            // zero-length read: count holds at zero, byte not delivered
            if (bytes_left != 8'd0) begin
              res_next.read_valid = 1'b1;
              res_next.read_data  = s1_item.received_byte;
              bytes_left_next     = bytes_left - 8'd1;
            end
            phase_next           = PH_ACK;
            res_next.bus_command = CMD_ACK;
            res_next.ack_level   = (bytes_left_next == 8'd0);
          end
          PH_ACK: begin
            if (bytes_left != 8'd0) begin
              phase_next           = PH_RX;
              res_next.bus_command = CMD_RECV;
            end else begin
              phase_next           = PH_STOP;
              res_next.bus_command = CMD_STOP;
            end
          end
          default: begin
            phase_next     = PH_IDLE;
            busy_flag_next = 1'b0;
          end
        endcase
      end
    end

    res_next.busy_res = busy_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      target_address   <= '0;
      register_pointer <= '0;
      bytes_left       <= '0;
      read_mode        <= 1'b0;
      busy_flag        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (step) begin
        phase            <= phase_next;
        target_address   <= target_address_next;
        register_pointer <= register_pointer_next;
        bytes_left       <= bytes_left_next;
        read_mode        <= read_mode_next;
        busy_flag        <= busy_flag_next;
        res              <= res_next;
      end
      if (core_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

// ===== src/i2c_master_register_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// I2C master register sequencer, top level
// Accepts one request or bus-step event per cycle while not stalled, and
// returns one result for each: an input register feeds the phase
// state machine, whose result register drives the output. The sustained rate
// is one transfer per clock; out_stall backs up through both registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_register_sequencer_top_defines.svh"

module i2c_master_register_sequencer_top
  import i2cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [6:0]  device_address,
  input  logic [15:0] register_address,
  input  logic [7:0]  transfer_length,
  input  logic        nack_seen,
  input  logic [7:0]  received_byte,
  input  logic [7:0]  next_write_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  bus_command,
  output logic [7:0]  command_byte,
  output logic        ack_level,
  output logic        write_byte_taken,
  output logic        read_valid,
  output logic [7:0]  read_data,
  output logic        busy_res,
  output logic        rejected
);

  item_t   in_item, s1_item;
  logic    s1_valid, core_ready;
  result_t res;

  assign in_item = '{operation:        operation,
                     device_address:   device_address,
                     register_address: register_address,
                     transfer_length:  transfer_length,
                     nack_seen:        nack_seen,
                     received_byte:    received_byte,
                     next_write_byte:  next_write_byte};

  i2cms_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .core_ready (core_ready),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item)
  );

  i2cms_core u_core (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .core_ready (core_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign bus_command      = res.bus_command;
  assign command_byte     = res.command_byte;
  assign ack_level        = res.ack_level;
  assign write_byte_taken = res.write_byte_taken;
  assign read_valid       = res.read_valid;
  assign read_data        = res.read_data;
  assign busy_res         = res.busy_res;
  assign rejected         = res.rejected;

  `ASSERT_NEXT(a_in_to_s1, in_valid && !in_stall, s1_valid, "accepted transfer lost")
  `ASSERT_SAME(a_rej_none, out_valid && rejected, bus_command == CMD_NONE && busy_res, "rejected request issued a command")
  `ASSERT_SAME(a_rd_ack, out_valid && read_valid, bus_command == CMD_ACK, "read data without ack")
  `ASSERT_SAME(a_wb_send, out_valid && write_byte_taken, bus_command == CMD_SEND && busy_res, "write byte taken without send")

endmodule
